// File: rtl/core/indexed_list_store_top_assert.svh
// Assertion macros for the list store.
// Both expect clk_i and rst_ni in scope; checks are off while reset is low.
`ifndef INDEXED_LIST_STORE_TOP_ASSERT_SVH
`define INDEXED_LIST_STORE_TOP_ASSERT_SVH

// Same-cycle implication
`define ILS_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ILS_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/ils_pkg.sv
package ils_pkg;

  // Request codes
  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_READ   = 3'd2,
    OP_MODIFY = 3'd3,
    OP_DELETE = 3'd4
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Field widths
  localparam int unsigned OpW    = 3;
  localparam int unsigned PosW   = 8;
  localparam int unsigned ValW   = 32;
  localparam int unsigned StW    = 2;
  localparam int unsigned CountW = 7;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 48;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_PUT,
    S_RD_ISSUE,
    S_RD_WAIT,
    S_DEL_RD,
    S_DEL_WR
  } state_e;

endpackage

// File: rtl/core/indexed_list_store_top.sv
// Bounded ordered list of signed 32-bit words held in a single-port-write RAM of
// CAPACITY entries. Each request word carries an operation (append, insert at
// position, read, modify, delete), a position and a value, and yields exactly one
// result word with the value read, a status (ok, out of range, full), the element
// count after the operation and an empty flag. One request is handled at a time
// and the input is ready only while the sequencer is idle and no finished result
// is waiting for the output register; a finished result sits in the output
// register, so the next request may be taken before it is drained.
// Each entry moved by insert or delete is one registered read from the RAM
// followed by one write, stepped by a single index adder.
// The count output is 7 bits wide and wraps for a CAPACITY above 127.
module indexed_list_store_top #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // s_axis_tdata: operation[2:0], position[10:3], value[42:11], zero fill
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [ils_pkg::InDataW-1:0]    s_axis_tdata,
  // m_axis_tdata: read_value[31:0], status[33:32], element_count[40:34],
  // is_empty[41], zero fill
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [ils_pkg::OutDataW-1:0]   m_axis_tdata
);

  import ils_pkg::*;

  `include "indexed_list_store_top_assert.svh"

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned LW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = (LW > PosW) ? LW : PosW;

  // Input word fields
  logic [OpW-1:0]  in_op;
  logic [PosW-1:0] in_pos;
  logic [ValW-1:0] in_val;
  assign in_op  = s_axis_tdata[OpW-1:0];
  assign in_pos = s_axis_tdata[OpW+PosW-1:OpW];
  assign in_val = s_axis_tdata[OpW+PosW+ValW-1:OpW+PosW];

  state_e          state_q, state_d;
  logic [LW-1:0]   len_q, len_d;
  logic [LW-1:0]   idx_q, idx_d;
  logic [LW-1:0]   pos_q, pos_d;
  logic [OpW-1:0]  op_q, op_d;
  logic [ValW-1:0] val_q, val_d;
  logic [ValW-1:0] rd_q, rd_d;
  logic [StW-1:0]  st_q, st_d;
  logic            done_q, done_d;
  logic            m_valid_q, m_valid_d;
  logic [OutDataW-1:0] m_data_q, m_data_d;

  // RAM port
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [ValW-1:0] ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [ValW-1:0] ram_rdata;

  ils_ram #(
    .Width (ValW),
    .Depth (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Shared index stepper: down while shifting up for insert, up for delete
  logic          step_dec;
  logic [LW-1:0] idx_step;
  assign step_dec = (state_q == S_INS_RD) || (state_q == S_INS_WR);
  assign idx_step = idx_q + (step_dec ? {LW{1'b1}} : LW'(1));

  // Range and fill checks on the incoming word
  logic in_range;
  logic is_full;
  assign in_range = CW'(in_pos) < CW'(len_q);
  assign is_full  = len_q >= LW'(CAPACITY);

  // Result word assembly
  logic [CW-1:0]     cnt_ext;
  logic [CountW-1:0] cnt_out;
  assign cnt_ext = CW'(len_q);
  assign cnt_out = cnt_ext[CountW-1:0];

  assign s_axis_tready = (state_q == S_IDLE) && !done_q;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Sequencer: next state, datapath controls and RAM port
  always_comb begin
    state_d   = state_q;
    len_d     = len_q;
    idx_d     = idx_q;
    pos_d     = pos_q;
    op_d      = op_q;
    val_d     = val_q;
    rd_d      = rd_q;
    st_d      = st_q;
    done_d    = 1'b0;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = idx_step[AW-1:0];

    // output register drains independently
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (done_q) begin
          // hand the finished result over once the output register is free
          if (m_valid_d) begin
            done_d = 1'b1;
          end else begin
            m_valid_d = 1'b1;
            m_data_d  = {{(OutDataW-ValW-StW-CountW-1){1'b0}},
                         (cnt_out == '0), cnt_out, st_q, rd_q};
          end
        end else if (s_axis_tvalid) begin
          op_d  = in_op;
          val_d = in_val;
          rd_d  = '0;
          st_d  = ST_OK;
          idx_d = len_q;
          pos_d = LW'(in_pos);
          case (in_op)
            OP_APPEND, OP_INSERT: begin
              if (is_full) begin
                st_d   = ST_FULL;
                done_d = 1'b1;
              end else begin
                if (in_op == OP_APPEND || !in_range) begin
                  pos_d = len_q;
                end
                state_d = S_INS_RD;
              end
            end
            OP_READ, OP_MODIFY, OP_DELETE: begin
              if (!in_range) begin
                st_d   = ST_RANGE;
                done_d = 1'b1;
              end else begin
                idx_d = LW'(in_pos);
                case (in_op)
                  OP_READ:   state_d = S_RD_ISSUE;
                  OP_MODIFY: state_d = S_PUT;
                  default:   state_d = S_DEL_RD;
                endcase
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_INS_RD: begin
        // fetch entry below the index while it lies above the target
        if (idx_q > pos_q) begin
          state_d = S_INS_WR;
        end else begin
          state_d = S_PUT;
        end
      end
      S_INS_WR: begin
        ram_we  = 1'b1;
        idx_d   = idx_step;
        state_d = S_INS_RD;
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q[AW-1:0];
        ram_wdata = val_q;
        if (op_q != OP_MODIFY) begin
          len_d = len_q + LW'(1);
        end
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      S_RD_ISSUE: begin
        ram_raddr = pos_q[AW-1:0];
        state_d   = S_RD_WAIT;
      end
      S_RD_WAIT: begin
        rd_d    = ram_rdata;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      S_DEL_RD: begin
        // pull the next entry down while one remains above the index
        if (idx_step < len_q) begin
          state_d = S_DEL_WR;
        end else begin
          len_d   = len_q - LW'(1);
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_DEL_WR: begin
        ram_we  = 1'b1;
        idx_d   = idx_step;
        state_d = S_DEL_RD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      len_q     <= '0;
      done_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      len_q     <= len_d;
      done_q    <= done_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    pos_q    <= pos_d;
    op_q     <= op_d;
    val_q    <= val_d;
    rd_q     <= rd_d;
    st_q     <= st_d;
    m_data_q <= m_data_d;
  end

  // Check terms
  logic idx_ok;
  logic len_frozen;
  assign idx_ok     = (idx_q <= len_q) && (idx_q < LW'(CAPACITY));
  assign len_frozen = state_q inside {S_IDLE, S_RD_ISSUE, S_RD_WAIT, S_INS_WR, S_DEL_WR};

  // Checks
  `ILS_CHECK(a_len_bound, 1'b1, len_q <= LW'(CAPACITY), "element count above capacity")
  `ILS_CHECK(a_ins_idx, step_dec, idx_ok, "insert index out of bounds")
  `ILS_CHECK_NEXT(a_len_src, len_frozen, $stable(len_q), "count changed outside put or delete end")
  `ILS_CHECK(a_no_accept_pending, done_q, !s_axis_tready, "input ready while result pending")

endmodule

// File: rtl/core/ils_ram.sv
module ils_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
